FILE: rtl/bfa_pkg.sv
package bfa_pkg;

  localparam int unsigned FRAME_BYTES_DEF = 4096;
  localparam int unsigned NUM_FRAMES_DEF  = 65536;

  localparam int unsigned CNT_W    = 17;
  localparam int unsigned ADDR_W   = 48;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned ALIGN_W  = 32;
  localparam int unsigned OADDR_W  = 28;
  localparam int unsigned CAND_W   = 34;

  localparam logic [CNT_W-1:0] CNT_MAX = 17'h1FFFF;

  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_FREE    = 2'd1;
  localparam logic [1:0] MODE_RESERVE = 2'd2;

endpackage

FILE: rtl/bfa_map_ram.sv
module bfa_map_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [63:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [63:0]   rdata_o
);

  logic [63:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/bitmap_frame_allocator.sv
// Channel   | Dir | Handshake                     | Payload
// s_axis    | in  | s_axis_tvalid / s_axis_tready | tuser: mode; tdata: address, count, align
// m_axis    | out | m_axis_tvalid / m_axis_tready | tuser: ok; tdata: alloc_address, free_frames
// cfg       | in  | cfg_valid_i / cfg_ready_o     | cfg_data_i: frame_count
//
// Free and reserve read, modify and write back each bitmap word touched in turn
// (S_RRD, S_RWT, S_RWR). Allocate scans one frame per cycle while no word fetch
// (S_ARD, S_AWT) is under way; it fetches anew at each word end or alignment jump,
// then marks its words in the same way; a single map RAM port pair sets this pace.
// After reset an init pass (S_INIT) writes every map word to used; s_axis_tready
// stays low meanwhile. A result waiting on m_axis lets one more transfer in, then
// holds that item in S_DONE until m_axis frees.
module bitmap_frame_allocator #(
  parameter int unsigned FRAME_BYTES = bfa_pkg::FRAME_BYTES_DEF,
  parameter int unsigned NUM_FRAMES  = bfa_pkg::NUM_FRAMES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [111:0]  s_axis_tdata,  // address[47:0], count[79:48], align[111:80]
  input  logic [1:0]    s_axis_tuser,  // mode[1:0]
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [47:0]   m_axis_tdata,  // alloc_address[27:0], free_frames[44:28], zero fill
  output logic          m_axis_tuser,  // ok
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [16:0]   cfg_data_i
);

  localparam int unsigned LG        = $clog2(FRAME_BYTES);
  localparam int unsigned MAP_WORDS = (NUM_FRAMES + 63) / 64;
  localparam int unsigned AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned FW        = $clog2(NUM_FRAMES + 1);
  localparam int unsigned WW        = FW - 6;
  localparam int unsigned CW        = bfa_pkg::CAND_W;
  localparam int unsigned NW        = bfa_pkg::CNT_W;

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_ARD  = 4'd2;
  localparam logic [3:0] S_AWT  = 4'd3;
  localparam logic [3:0] S_ACHK = 4'd4;
  localparam logic [3:0] S_RRD  = 4'd5;
  localparam logic [3:0] S_RWT  = 4'd6;
  localparam logic [3:0] S_RWR  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0]    state_q, state_d;
  logic [AW-1:0] init_q;
  logic [16:0]   frame_count_q;
  logic [NW-1:0] cnt_q, cnt_d;
  logic          m_valid_q;
  logic          out_ok_q;
  logic [27:0]   out_addr_q;
  logic [NW-1:0] out_free_q;

  logic          res_ok_q, res_ok_d;
  logic [27:0]   res_addr_q, res_addr_d;
  logic [31:0]   count_q, count_d;
  logic [31:0]   step_q, step_d;
  logic [CW-1:0] cand_q, cand_d, pos_q, pos_d, ph_q, ph_d;
  logic [FW-1:0] first_q, first_d, end_q, end_d;
  logic [WW-1:0] wi_q, wi_d;
  logic          used_q, used_d;
  logic [63:0]   wq_q, wq_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [63:0]   ram_wdata, ram_rdata;

  logic [FW-1:0] lim;
  logic [47:0]   in_address, first_full;
  logic [31:0]   in_count, in_align, astep;
  logic [32:0]   rsv_frames, rng_n;
  logic [CW-1:0] end_c, cand_n, ph_inc;
  logic [63:0]   lo_m, hi_m, mask, chg, new_word;
  logic [6:0]    pc;
  logic [NW:0]   cnt_sum;
  logic [FW:0]   next_base;
  logic          accept, out_free_slot;

  assign in_address = s_axis_tdata[47:0];
  assign in_count   = s_axis_tdata[79:48];
  assign in_align   = s_axis_tdata[111:80];

  assign lim = ({15'd0, frame_count_q} > 32'(NUM_FRAMES)) ? FW'(NUM_FRAMES)
                                                        : FW'(frame_count_q);

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free_slot = !m_valid_q || m_axis_tready;

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = out_ok_q;
  assign m_axis_tdata  = {3'd0, out_free_q, out_addr_q};

  assign first_full = in_address >> LG;
  assign rsv_frames = ({1'b0, in_count} + 33'(FRAME_BYTES - 1)) >> LG;
  assign rng_n      = (s_axis_tuser == bfa_pkg::MODE_RESERVE) ? rsv_frames : {1'b0, in_count};
  assign astep      = in_align >> LG;

  assign end_c  = cand_q + CW'(count_q);
  assign cand_n = pos_q - ph_q + CW'(step_q);
  assign ph_inc = ph_q + CW'(1);

  assign lo_m = (first_q[FW-1:6] == wi_q) ? ({64{1'b1}} << first_q[5:0]) : {64{1'b1}};
  assign hi_m = (end_q[FW-1:6] == wi_q) ? ~({64{1'b1}} << end_q[5:0]) : {64{1'b1}};
  assign mask = lo_m & hi_m;
  assign chg      = used_q ? (mask & ~wq_q) : (mask & wq_q);
  assign new_word = used_q ? (wq_q | mask) : (wq_q & ~mask);
  assign pc       = 7'($countones(chg));
  assign cnt_sum  = {1'b0, cnt_q} + (NW+1)'(pc);
  assign next_base = {1'b0, wi_q, 6'd0} + (FW+1)'(64);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(wi_q);
    ram_wdata = new_word;
    ram_raddr = AW'(wi_q);
    if (state_q == S_INIT) begin
      ram_we    = 1'b1;
      ram_waddr = init_q;
      ram_wdata = {64{1'b1}};
    end else if (state_q == S_RWR) begin
      ram_we = 1'b1;
    end
    if (state_q == S_ARD) begin
      ram_raddr = AW'(pos_q >> 6);
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    res_ok_d   = res_ok_q;
    res_addr_d = res_addr_q;
    count_d    = count_q;
    step_d     = step_q;
    cand_d     = cand_q;
    pos_d      = pos_q;
    ph_d       = ph_q;
    first_d    = first_q;
    end_d      = end_q;
    wi_d       = wi_q;
    used_d     = used_q;
    wq_d       = wq_q;
    unique case (state_q)
      S_INIT: begin
        if (init_q == AW'(MAP_WORDS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          res_ok_d   = 1'b1;
          res_addr_d = '0;
          priority if (s_axis_tuser == bfa_pkg::MODE_ALLOC) begin
            count_d = in_count;
            step_d  = (astep == 32'd0) ? 32'd1 : astep;
            cand_d  = '0;
            pos_d   = '0;
            ph_d    = '0;
            if (in_count == 32'd0) begin
              res_ok_d = 1'b0;
              state_d  = S_DONE;
            end else begin
              state_d = S_ARD;
            end
          end else if (s_axis_tuser == bfa_pkg::MODE_FREE ||
                       s_axis_tuser == bfa_pkg::MODE_RESERVE) begin
            used_d = (s_axis_tuser == bfa_pkg::MODE_RESERVE);
            if (first_full >= 48'(lim)) begin
              state_d = S_DONE;
            end else begin
              first_d = FW'(first_full);
              wi_d    = first_full[FW-1:6];
              end_d   = (48'(rng_n) >= (48'(lim) - first_full)) ? lim
                                                              : FW'(first_full + 48'(rng_n));
              state_d = S_RRD;
            end
          end else begin
            res_ok_d = 1'b0;
            state_d  = S_DONE;
          end
        end
      end
      S_ARD: state_d = S_AWT;
      S_AWT: begin
        wq_d    = ram_rdata;
        state_d = S_ACHK;
      end
      S_ACHK: begin
        priority if (end_c > CW'(lim)) begin
          res_ok_d = 1'b0;
          state_d  = S_DONE;
        end else if (pos_q == end_c) begin
          res_addr_d = 28'(cand_q << LG);
          first_d    = FW'(cand_q);
          end_d      = FW'(end_c);
          wi_d       = cand_q[FW-1:6];
          used_d     = 1'b1;
          state_d    = S_RRD;
        end else if (wq_q[pos_q[5:0]]) begin
          cand_d  = cand_n;
          pos_d   = cand_n;
          ph_d    = '0;
          state_d = S_ARD;
        end else begin
          pos_d = pos_q + CW'(1);
          ph_d  = ((CW+1)'(ph_inc) == (CW+1)'(step_q)) ? '0 : ph_inc;
          if (pos_q[5:0] == 6'd63) state_d = S_ARD;
        end
      end
      S_RRD: state_d = S_RWT;
      S_RWT: begin
        wq_d    = ram_rdata;
        state_d = S_RWR;
      end
      S_RWR: begin
        if (used_q) begin
          cnt_d = (cnt_q >= NW'(pc)) ? (cnt_q - NW'(pc)) : '0;
        end else begin
          cnt_d = (cnt_sum > (NW+1)'(bfa_pkg::CNT_MAX)) ? bfa_pkg::CNT_MAX : cnt_sum[NW-1:0];
        end
        if (next_base >= {1'b0, end_q}) begin
          state_d = S_DONE;
        end else begin
          wi_d    = wi_q + WW'(1);
          state_d = S_RRD;
        end
      end
      S_DONE: begin
        if (out_free_slot) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_INIT;
      init_q        <= '0;
      frame_count_q <= '0;
      cnt_q         <= '0;
      m_valid_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (state_q == S_INIT) init_q <= init_q + AW'(1);
      if (cfg_valid_i) frame_count_q <= cfg_data_i;
      if (state_q == S_DONE && out_free_slot) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_ok_q   <= res_ok_d;
    res_addr_q <= res_addr_d;
    count_q    <= count_d;
    step_q     <= step_d;
    cand_q     <= cand_d;
    pos_q      <= pos_d;
    ph_q       <= ph_d;
    first_q    <= first_d;
    end_q      <= end_d;
    wi_q       <= wi_d;
    used_q     <= used_d;
    wq_q       <= wq_d;
    if (state_q == S_DONE && out_free_slot) begin
      out_ok_q   <= res_ok_q;
      out_addr_q <= res_ok_q ? res_addr_q : '0;
      out_free_q <= cnt_q;
    end
  end

  bfa_map_ram #(
    .DEPTH (MAP_WORDS),
    .AW    (AW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

FILE: tb/bitmap_frame_allocator_tb.sv
module bitmap_frame_allocator_tb;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned FRAMES    = bfa_pkg::NUM_FRAMES_DEF;
  localparam int unsigned FBYTES    = bfa_pkg::FRAME_BYTES_DEF;
  localparam longint unsigned CYCLE_LIMIT = 20_000_000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [47:0] address;
    logic [31:0] count;
    logic [31:0] align;
  } frame_req_t;

  typedef struct packed {
    logic        ok;
    logic [27:0] alloc_address;
    logic [16:0] free_frames;
  } frame_rsp_t;

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready;
  logic [111:0] s_axis_tdata;
  logic [1:0] s_axis_tuser;
  logic m_axis_tvalid, m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_valid_i, cfg_ready_o;
  logic [16:0] cfg_data_i;

  bitmap_frame_allocator dut (.*);

  frame_req_t req_q[$];
  frame_rsp_t rsp_expected_q[$];
  bit used_map[FRAMES];
  logic [16:0] free_cnt, frame_limit_reg;
  int errors = 0;
  bit in_xfer = 0;
  int burst_left = 0, gap_left = 0;
  int hold_asked = 0, hold_taken = 0, hold_left = 0;
  int rx_pattern = 0, rx_tick = 0;
  longint unsigned cycles = 0;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("bitmap_frame_allocator regression: fail");
      $finish;
    end
  end

  function automatic longint unsigned active_frames();
    return (frame_limit_reg > FRAMES) ? FRAMES : frame_limit_reg;
  endfunction

  function automatic void take_frames(longint unsigned n);
    free_cnt = (n >= free_cnt) ? 17'd0 : free_cnt - 17'(n);
  endfunction

  function automatic void mark_span(longint unsigned first, longint unsigned n, bit used);
    longint unsigned lim, stop;
    lim = active_frames();
    if (first >= lim) return;
    stop = (n >= lim - first) ? lim : first + n;
    for (longint unsigned f = first; f < stop; f++) begin
      if (used_map[f] != used) begin
        used_map[f] = used;
        if (used) take_frames(1);
        else if (free_cnt < bfa_pkg::CNT_MAX) free_cnt++;
      end
    end
  endfunction

  function automatic frame_rsp_t predict_alloc_op(frame_req_t r);
    frame_rsp_t rsp;
    longint unsigned lim, stride, f, cnt, u, res_frames;
    bit hit;
    rsp = '0;
    case (r.mode)
      bfa_pkg::MODE_ALLOC: begin
        lim = active_frames();
        cnt = r.count;
        stride = r.align / FBYTES;
        if (stride == 0) stride = 1;
        f = 0;
        if (cnt != 0) begin
          while (f + cnt <= lim) begin
            hit = 0;
            u = 0;
            for (longint unsigned j = 0; j < cnt; j++) begin
              if (used_map[f + j]) begin
                hit = 1;
                u = f + j;
                break;
              end
            end
            if (!hit) begin
              for (longint unsigned j = 0; j < cnt; j++) used_map[f + j] = 1;
              take_frames(cnt);
              rsp.ok = 1;
              rsp.alloc_address = 28'(f * FBYTES);
              break;
            end
            f = (u / stride + 1) * stride;
          end
        end
      end
      bfa_pkg::MODE_FREE: begin
        mark_span(r.address / FBYTES, r.count, 0);
        rsp.ok = 1;
      end
      bfa_pkg::MODE_RESERVE: begin
        res_frames = (longint'(r.count) + FBYTES - 1) / FBYTES;
        mark_span(r.address / FBYTES, res_frames, 1);
        rsp.ok = 1;
      end
      default: ;
    endcase
    rsp.free_frames = free_cnt;
    return rsp;
  endfunction

  always @(posedge clk_i) begin
    frame_req_t r;
    frame_rsp_t got, want;
    in_xfer = rst_ni && s_axis_tvalid && s_axis_tready;
    if (in_xfer) begin
      r.mode = s_axis_tuser;
      {r.align, r.count, r.address} = s_axis_tdata;
      rsp_expected_q.push_back(predict_alloc_op(r));
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.ok = m_axis_tuser;
      got.alloc_address = m_axis_tdata[27:0];
      got.free_frames = m_axis_tdata[44:28];
      if (rsp_expected_q.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        want = rsp_expected_q.pop_front();
        if (got.ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, got.ok);
          errors++;
        end
        if (got.alloc_address !== want.alloc_address) begin
          $error("alloc_address: expected %h, got %h", want.alloc_address, got.alloc_address);
          errors++;
        end
        if (got.free_frames !== want.free_frames) begin
          $error("free_frames: expected %0d, got %0d", want.free_frames, got.free_frames);
          errors++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    logic nxt_valid;
    frame_req_t cur;
    if (in_xfer) begin
      void'(req_q.pop_front());
      if (burst_left > 0) burst_left--;
    end
    nxt_valid = s_axis_tvalid && !in_xfer;
    if (!nxt_valid) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end
      if (gap_left > 0) begin
        gap_left--;
      end else if (req_q.size() > 0) begin
        nxt_valid = 1;
        cur = req_q[0];
        s_axis_tuser <= cur.mode;
        s_axis_tdata <= {cur.align, cur.count, cur.address};
      end
    end
    s_axis_tvalid <= nxt_valid;
  end

  always @(negedge clk_i) begin
    logic rdy;
    rx_tick++;
    if (rx_tick % 97 == 0) rx_pattern = $urandom_range(0, 2);
    if (hold_left == 0 && hold_taken != hold_asked) begin
      hold_taken = hold_asked;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      rdy = 0;
    end else begin
      case (rx_pattern)
        0: rdy = 1;
        1: rdy = $urandom_range(0, 1);
        default: rdy = ($urandom_range(0, 3) == 0);
      endcase
    end
    m_axis_tready <= rdy;
  end

  task automatic add_req(logic [1:0] m, logic [47:0] a, logic [31:0] c, logic [31:0] al);
    frame_req_t r;
    r.mode = m;
    r.address = a;
    r.count = c;
    r.align = al;
    req_q.push_back(r);
  endtask

  task automatic drain_all();
    while (req_q.size() > 0 || s_axis_tvalid || rsp_expected_q.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_frame_count(logic [16:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    frame_limit_reg = v;
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  function automatic logic [47:0] pick_address(int unsigned lim);
    if ($urandom_range(0, 4) == 0) return {16'($urandom), 32'($urandom)};
    return 48'($urandom_range(0, lim + 8)) * FBYTES + 48'($urandom_range(0, FBYTES - 1));
  endfunction

  function automatic logic [31:0] pick_frames(int unsigned lim);
    int unsigned k;
    k = $urandom_range(0, 19);
    if (k < 17) return $urandom_range(1, 16);
    if (k < 19) return $urandom_range(0, lim + 2);
    return $urandom;
  endfunction

  task automatic add_random_req(int unsigned lim);
    int unsigned k;
    logic [31:0] al;
    k = $urandom_range(0, 19);
    case ($urandom_range(0, 9))
      0, 1, 2: al = $urandom_range(0, FBYTES - 1);
      3, 4, 5: al = (32'd1 << $urandom_range(0, 4)) * FBYTES;
      6: al = $urandom;
      default: al = 0;
    endcase
    if (k < 9)
      add_req(bfa_pkg::MODE_ALLOC, pick_address(lim), pick_frames(lim), al);
    else if (k < 14)
      add_req(bfa_pkg::MODE_FREE, pick_address(lim), pick_frames(lim), al);
    else if (k < 19)
      add_req(bfa_pkg::MODE_RESERVE, pick_address(lim),
              ($urandom_range(0, 6) == 0) ? $urandom : $urandom_range(0, 16 * FBYTES), al);
    else
      add_req(MODE_UNUSED, pick_address(lim), $urandom, $urandom);
  endtask

  initial begin
    int unsigned lim;
    rst_ni = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 0;
    cfg_valid_i = 0;
    cfg_data_i = '0;
    foreach (used_map[i]) used_map[i] = 1;
    free_cnt = 0;
    frame_limit_reg = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    add_req(bfa_pkg::MODE_ALLOC, 48'd0, 32'd1, 32'd0);
    add_req(bfa_pkg::MODE_FREE, 48'd0, 32'd5, 32'd0);
    add_req(MODE_UNUSED, '1, '1, '1);
    drain_all();

    write_frame_count(17'd65536);
    add_req(bfa_pkg::MODE_FREE, 48'd0, 32'hFFFF_FFFF, 32'd0);
    add_req(bfa_pkg::MODE_RESERVE, 48'd0, 32'h0010_0000, 32'd0);
    add_req(bfa_pkg::MODE_ALLOC, 48'd0, 32'd1, 32'd0);
    add_req(bfa_pkg::MODE_ALLOC, 48'd0, 32'd3, 32'h0001_0000);
    add_req(bfa_pkg::MODE_ALLOC, 48'd0, 32'd0, 32'd0);
    add_req(bfa_pkg::MODE_ALLOC, 48'd0, 32'd65536, 32'd0);
    add_req(bfa_pkg::MODE_FREE, 48'h0020_0000, 32'd4, 32'd0);
    add_req(bfa_pkg::MODE_RESERVE, 48'h0000_1000, 32'd1, 32'd0);
    add_req(bfa_pkg::MODE_RESERVE, '1, '1, 32'd0);
    add_req(bfa_pkg::MODE_FREE, '1, '1, 32'd0);
    add_req(bfa_pkg::MODE_ALLOC, 48'd0, '1, '1);
    add_req(bfa_pkg::MODE_ALLOC, 48'd0, 32'd2, 32'd4095);
    add_req(bfa_pkg::MODE_RESERVE, 48'h0FFF_F000, 32'd4096, 32'd0);
    add_req(bfa_pkg::MODE_FREE, 48'h0FFF_F000, 32'd1, 32'd0);
    add_req(bfa_pkg::MODE_ALLOC, 48'd0, 32'd1, 32'hFFFF_F000);
    drain_all();

    write_frame_count(17'h1FFFF);
    add_req(bfa_pkg::MODE_ALLOC, 48'd0, 32'd10, 32'd8192);
    add_req(bfa_pkg::MODE_FREE, 48'h0FFF_E123, 32'd3, 32'd0);
    drain_all();

    write_frame_count(17'd100);
    add_req(bfa_pkg::MODE_ALLOC, 48'd0, 32'd4, 32'd0);
    add_req(bfa_pkg::MODE_FREE, 48'd0, 32'd0, 32'd0);
    add_req(bfa_pkg::MODE_RESERVE, 48'd0, 32'd1, 32'd0);
    add_req(bfa_pkg::MODE_RESERVE, 48'h0000_2000, 32'd0, 32'd0);
    drain_all();

    write_frame_count(17'd0);
    add_req(bfa_pkg::MODE_RESERVE, 48'd0, 32'd4096, 32'd0);
    drain_all();

    for (int ph = 0; ph < 10; ph++) begin
      lim = (ph == 9) ? 64 : $urandom_range(1, 400);
      write_frame_count(17'(lim));
      if (ph == 3) hold_asked++;
      add_req(bfa_pkg::MODE_FREE, 48'd0, lim / 2 + 1, 32'd0);
      for (int i = 0; i < 107; i++) add_random_req(lim);
      drain_all();
    end

    if (errors == 0) begin
      $display("bitmap_frame_allocator regression: pass");
    end else begin
      $display("bitmap_frame_allocator regression: fail");
    end
    $finish;
  end
endmodule
